/* hw/rtl/prim_pkg.sv */
`default_nettype none
package prim_pkg;
	localparam int BASE_CNT = 4;
	localparam logic [31:0] BASE_2 = 32'd2;
	localparam logic [31:0] BASE_1215 = 32'd1215;
	localparam logic [31:0] BASE_34862 = 32'd34862;
	localparam logic [31:0] BASE_574237825 = 32'd574237825;
	localparam logic [31:0] SKIP_34862 = 32'd17431;
	localparam logic [31:0] SKIP_574237825 = 32'd3281359;
	localparam logic [4:0] SMALL_LIMIT = 5'd29;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCREEN,
		ST_BRED,
		ST_SPLIT,
		ST_EXP_MUL,
		ST_EXP_SQR,
		ST_CHECK,
		ST_SQ_LOOP,
		ST_NEXT,
		ST_DONE
	} state_t;

	// small prime table
	function automatic logic [4:0] small_prime(input logic [3:0] idx);
		logic [4:0] p;
		unique case (idx)
			4'd0: p = 5'd2;
			4'd1: p = 5'd3;
			4'd2: p = 5'd5;
			4'd3: p = 5'd7;
			4'd4: p = 5'd11;
			4'd5: p = 5'd13;
			4'd6: p = 5'd17;
			4'd7: p = 5'd19;
			4'd8: p = 5'd23;
			default: p = 5'd1;
		endcase
		return p;
	endfunction

	function automatic logic [31:0] base_val(input logic [1:0] idx);
		logic [31:0] b;
		unique case (idx)
			2'd0: b = BASE_2;
			2'd1: b = BASE_1215;
			2'd2: b = BASE_34862;
			default: b = BASE_574237825;
		endcase
		return b;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/prim_if.sv */
`default_nettype none
interface prim_in_if #(parameter int W = 40);
	logic valid;
	logic ready;
	logic [W-1:0] candidate;
	modport source(output valid, output candidate, input ready);
	modport sink(input valid, input candidate, output ready);
endinterface

interface prim_out_if;
	logic valid;
	logic ready;
	logic is_prime;
	modport source(output valid, output is_prime, input ready);
	modport sink(input valid, input is_prime, output ready);
endinterface
`default_nettype wire

/* hw/rtl/prim_modmul.sv */
`default_nettype none
// bit-serial modular multiply: one multiplier bit per cycle, msb first
module prim_modmul #(
	parameter int W = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [W-1:0] x,
	input wire logic [W-1:0] y,
	input wire logic [W-1:0] m,
	output logic busy,
	output logic done,
	output logic [W-1:0] prod
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] acc_q;
	logic [W-1:0] y_q;
	logic [W-1:0] x_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] dbl;
	logic [W:0] dbl_r;
	logic [W:0] sum;
	logic [W-1:0] nxt;

	// one step: double, reduce, add, reduce
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		sum = dbl_r + (y_q[W-1] ? {1'b0, x_q} : '0);
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		nxt = sum[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			y_q <= y;
			x_q <= x;
		end else if (busy_q) begin
			acc_q <= nxt;
			y_q <= {y_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

/* hw/rtl/prim_modred.sv */
`default_nettype none
// restoring remainder, one quotient bit per cycle
module prim_modred #(
	parameter int W = 40,
	parameter int AW = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [AW-1:0] a,
	input wire logic [W-1:0] m,
	output logic done,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(AW + 1);
	logic [AW-1:0] a_q;
	logic [W-1:0] r_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [W:0] sh;

	assign sh = {r_q, a_q[AW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(AW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[AW-2:0], 1'b0};
			r_q <= (sh >= {1'b0, m}) ? W'(sh - {1'b0, m}) : sh[W-1:0];
		end
	end

	assign done = done_q;
	assign rem = r_q;
endmodule
`default_nettype wire

/* hw/rtl/primality_test.sv */
`default_nettype none
// channel  | dir | payload
// in_ch    | in  | candidate [N_BITS-1:0]
// out_ch   | out | is_prime
// the small-factor screen is up to 9 remainders of a max(N_BITS,32)-bit value; below 29
// the verdict is read from the small prime table instead; each of up to 4 bases adds a
// remainder and at most about 2*N_BITS multiplies
// reset clears the sequencer and the result register; a candidate is taken in idle even
// while an earlier result waits, and a finished verdict waits until that result leaves
module primality_test
	import prim_pkg::*;
#(
	parameter int N_BITS = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	prim_in_if.sink in_ch,
	prim_out_if.source out_ch
);
	localparam int RW = $clog2(N_BITS + 1);
	localparam int AW = (N_BITS > 32) ? N_BITS : 32;
	state_t state_q, state_d;
	logic [N_BITS-1:0] n_q, d_q, t_q, b_q;
	logic [RW-1:0] r_q, i_q;
	logic [3:0] sp_q;
	logic [1:0] base_q;
	logic verd_q;
	logic res_valid_q, res_q;
	logic [N_BITS-1:0] nm1;
	logic [N_BITS-1:0] n_in;
	logic in_acc;
	logic small_hit;
	logic last_base;
	logic res_load;

	// shared units
	logic mm_start, mm_busy, mm_done;
	logic [N_BITS-1:0] mm_x, mm_y, mm_p;
	logic rd_start, rd_done;
	logic [AW-1:0] rd_a;
	logic [N_BITS-1:0] rd_m, rd_r;
	logic rd_go_q, mm_go_q;
	logic rd_go_d, mm_go_d;

	prim_modmul #(.W(N_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mm_x), .y(mm_y),
		.m(n_q), .busy(mm_busy), .done(mm_done), .prod(mm_p)
	);
	prim_modred #(.W(N_BITS), .AW(AW)) u_red (
		.clk(clk), .arst_n(arst_n), .start(rd_start), .a(rd_a), .m(rd_m),
		.done(rd_done), .rem(rd_r)
	);

	assign nm1 = n_q - 1'b1;
	assign n_in = in_ch.candidate;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = res_valid_q;
	assign out_ch.is_prime = res_q;

	// compare against a constant without truncating either side
	function automatic logic eq_const(input logic [N_BITS-1:0] v, input logic [31:0] c);
		return AW'(v) == AW'(c);
	endfunction

	// direct answer for candidates below 29
	always_comb begin
		small_hit = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (n_in == N_BITS'(small_prime(4'(k)))) small_hit = 1'b1;
		end
	end

	// last base, with the two skips
	assign last_base = (base_q == 2'd3)
		|| (base_q == 2'd1 && eq_const(n_q, SKIP_34862))
		|| (base_q == 2'd2 && eq_const(n_q, SKIP_574237825));

	// operand selection
	always_comb begin
		rd_a = AW'(n_q);
		rd_m = N_BITS'(small_prime(sp_q));
		if (state_q == ST_BRED) begin
			rd_a = AW'(base_val(base_q));
			rd_m = n_q;
		end
		mm_x = t_q;
		mm_y = b_q;
		if (state_q == ST_EXP_SQR) begin
			mm_x = b_q;
		end else if (state_q == ST_SQ_LOOP) begin
			mm_y = t_q;
		end
		rd_start = rd_go_q;
		mm_start = mm_go_q;
	end

	// sequencer next state and unit starts
	always_comb begin
		state_d = state_q;
		rd_go_d = 1'b0;
		mm_go_d = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (n_in < N_BITS'(SMALL_LIMIT)) begin
						state_d = ST_DONE;
					end else begin
						rd_go_d = 1'b1;
						state_d = ST_SCREEN;
					end
				end
			end
			ST_SCREEN: begin
				if (rd_done) begin
					if (rd_r == '0) begin
						state_d = ST_DONE;
					end else begin
						rd_go_d = 1'b1;
						if (sp_q == 4'd8) state_d = ST_BRED;
					end
				end
			end
			ST_BRED: begin
				if (rd_done) state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				if (d_q[0]) begin
					mm_go_d = 1'b1;
					state_d = ST_EXP_MUL;
				end
			end
			ST_EXP_MUL: begin
				if (mm_done) begin
					mm_go_d = 1'b1;
					state_d = ST_EXP_SQR;
				end else if (!mm_busy && !mm_go_q) begin
					if (d_q == '0) begin
						state_d = ST_CHECK;
					end else begin
						mm_go_d = 1'b1;
						if (!d_q[0]) state_d = ST_EXP_SQR;
					end
				end
			end
			ST_EXP_SQR: begin
				if (mm_done) state_d = ST_EXP_MUL;
			end
			ST_CHECK: begin
				if (t_q == N_BITS'(1) || t_q == nm1) begin
					state_d = ST_NEXT;
				end else if (r_q > RW'(1)) begin
					mm_go_d = 1'b1;
					state_d = ST_SQ_LOOP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SQ_LOOP: begin
				if (mm_done) begin
					if (mm_p == nm1) begin
						state_d = ST_NEXT;
					end else if (i_q + 1'b1 < r_q) begin
						mm_go_d = 1'b1;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_NEXT: begin
				if (last_base) begin
					state_d = ST_DONE;
				end else begin
					rd_go_d = 1'b1;
					state_d = ST_BRED;
				end
			end
			// hand the verdict to the result register once it is free
			ST_DONE: begin
				if (!res_valid_q || out_ch.ready) begin
					res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, starts and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_go_q <= 1'b0;
			mm_go_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_go_q <= rd_go_d;
			mm_go_q <= mm_go_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_q <= verd_q;
			end else if (out_ch.valid && out_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					n_q <= n_in;
					sp_q <= '0;
					base_q <= '0;
					verd_q <= small_hit;
				end
			end
			// trial remainders against small primes
			ST_SCREEN: begin
				if (rd_done) begin
					if (state_d == ST_DONE) begin
						verd_q <= 1'b0;
					end else if (state_d == ST_SCREEN) begin
						sp_q <= sp_q + 1'b1;
					end
				end
			end
			// reduce base mod n, set up exponent
			ST_BRED: begin
				if (rd_done) begin
					b_q <= rd_r;
					t_q <= N_BITS'(1);
					d_q <= nm1;
					r_q <= '0;
				end
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[N_BITS-1:1]};
					r_q <= r_q + 1'b1;
				end
			end
			// square-and-multiply, lsb first
			ST_EXP_MUL: begin
				if (mm_done) t_q <= mm_p;
			end
			ST_EXP_SQR: begin
				if (mm_done) begin
					b_q <= mm_p;
					d_q <= {1'b0, d_q[N_BITS-1:1]};
				end
			end
			ST_CHECK: begin
				i_q <= RW'(1);
				if (state_d == ST_DONE) verd_q <= 1'b0;
			end
			ST_SQ_LOOP: begin
				if (mm_done) begin
					t_q <= mm_p;
					if (mm_go_d) i_q <= i_q + 1'b1;
					if (state_d == ST_DONE) verd_q <= 1'b0;
				end
			end
			// advance base or finish as prime
			ST_NEXT: begin
				if (state_d == ST_DONE) begin
					verd_q <= 1'b1;
				end else begin
					base_q <= base_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* tb/primality_test_tb.sv */
`default_nettype none
module primality_test_tb;
	import prim_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_BITS = 40;
	localparam int SETTLE_CYCLES = 8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prim_in_if #(.W(N_BITS)) in_ch ();
	prim_out_if out_ch ();

	primality_test #(.N_BITS(N_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// verdicts still owed by the block, oldest first
	bit verdict_q[$];
	int error_cnt = 0;
	int hold_off = 0;
	bit no_gaps = 1'b0;

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.candidate = '0;
		out_ch.ready = 1'b0;
	end

	// (x * y) mod m by shift and add
	function automatic logic [N_BITS:0] mulmod(logic [N_BITS:0] x, logic [N_BITS:0] y,
			logic [N_BITS:0] m);
		logic [N_BITS:0] acc;
		acc = '0;
		for (int b = N_BITS - 1; b >= 0; b--) begin
			acc = acc << 1;
			if (acc >= m) acc = acc - m;
			if (y[b]) begin
				acc = acc + x;
				if (acc >= m) acc = acc - m;
			end
		end
		return acc;
	endfunction

	// strong probable prime test of odd m to base b
	function automatic bit strong_probable(logic [N_BITS:0] m, logic [31:0] b);
		logic [N_BITS:0] mm1, d, bb, t;
		int r;
		mm1 = m - 1;
		d = mm1;
		bb = b % m;
		t = 1;
		r = 0;
		while (d[0] == 1'b0 && d != 0) begin
			d = d >> 1;
			r++;
		end
		while (d != 0) begin
			if (d[0]) t = mulmod(t, bb, m);
			bb = mulmod(bb, bb, m);
			d = d >> 1;
		end
		if (t == 1 || t == mm1) return 1'b1;
		for (int i = 1; i < r; i++) begin
			t = mulmod(t, t, m);
			if (t == mm1) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit predict_prime(logic [N_BITS-1:0] cand);
		logic [N_BITS:0] n;
		int primes[9] = '{2, 3, 5, 7, 11, 13, 17, 19, 23};
		n = {1'b0, cand};
		if (n < SMALL_LIMIT) begin
			foreach (primes[i]) if (n == primes[i]) return 1'b1;
			return 1'b0;
		end
		foreach (primes[i]) if (n % primes[i] == 0) return 1'b0;
		if (!strong_probable(n, BASE_2)) return 1'b0;
		if (!strong_probable(n, BASE_1215)) return 1'b0;
		if (n == SKIP_34862) return 1'b1;
		if (!strong_probable(n, BASE_34862)) return 1'b0;
		if (n == SKIP_574237825) return 1'b1;
		return strong_probable(n, BASE_574237825);
	endfunction

	// random full-width candidate
	function automatic logic [N_BITS-1:0] rand_cand();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[N_BITS-1:0];
	endfunction

	// offer one candidate, wait for its beat
	task automatic send_candidate(logic [N_BITS-1:0] cand);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.candidate <= cand;
		do @(posedge clk); while (!in_ch.ready);
		verdict_q.insert(verdict_q.size(), predict_prime(cand));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls plus an optional long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (verdict_q.size() == 0) begin
				$error("is_prime: expected none, actual %0b", out_ch.is_prime);
				error_cnt++;
			end else begin
				bit want;
				want = verdict_q.pop_front();
				if (out_ch.is_prime !== want) begin
					$error("is_prime: expected %0b, actual %0b", want, out_ch.is_prime);
					error_cnt++;
				end
			end
		end
	end

	// extremes, small values and the skipped-base numbers
	task automatic test_directed();
		logic [N_BITS-1:0] vals[$] = '{0, 1, 2, 3, 4, 22, 23, 25, 28, 29, 31, 49, 529,
			17431, 3281359, 2047, 1373653, 25326001, 40'd3215031751,
			40'd1099511627775, 40'd1099511627689, 40'hFFFFFFFFFF - 40'd86,
			40'd999999999989, 40'h8000000001, 40'hAAAAAAAAAA};
		foreach (vals[i]) send_candidate(vals[i]);
	endtask

	// random widths, mostly odd numbers with no factor of 3, 5 or 7
	task automatic test_random();
		logic [N_BITS-1:0] c;
		int w;
		for (int i = 0; i < 115; i++) begin
			w = $urandom_range(5, N_BITS);
			c = rand_cand();
			c = c >> (N_BITS - w);
			if ($urandom_range(0, 3) != 0) begin
				c[0] = 1'b1;
				while (c % 3 == 0 || c % 5 == 0 || c % 7 == 0) c = c + 2;
			end
			send_candidate(c);
		end
	endtask

	// stall the output long enough for the input to back up
	task automatic test_backpressure();
		hold_off = 20000;
		no_gaps = 1'b1;
		for (int i = 0; i < 4; i++) send_candidate(rand_cand() | N_BITS'(1));
		no_gaps = 1'b0;
		drain();
	endtask

	// back-to-back with no idling
	task automatic test_streaming();
		no_gaps = 1'b1;
		for (int i = 0; i < 10; i++) send_candidate(rand_cand() | N_BITS'(1));
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		test_backpressure();
		test_streaming();
		test_random();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_cnt == 0 && verdict_q.size() == 0) begin
			$display("primality_test verification clean");
		end else begin
			$display("primality_test verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100ms;
		$display("primality_test verification failed");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/prim_pkg.sv
hw/rtl/prim_if.sv
hw/rtl/prim_modmul.sv
hw/rtl/prim_modred.sv
hw/rtl/primality_test.sv
tb/primality_test_tb.sv
